@@ sv/mtd_pkg.sv @@
// Package: shared types and codes for the multirate task dispatcher.
`timescale 1ns / 1ps
package mtd_pkg;

  localparam int ACTION_W = 4;
  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 24;
  localparam int TICK_W   = 16;
  localparam int CALLS_W  = 16;
  localparam int KIND_W   = 2;
  localparam int ERR_W    = 2;

  localparam logic [ACTION_W-1:0] ACT_TICK       = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_START      = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_STOP       = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_PAUSE      = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_RESUME     = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_SAVE_PAUSE = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_FREEZE_ALL = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_RESUME_ALL = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_SET_PERIOD = 4'd8;

  localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NO_SLOT    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NOT_ACTIVE = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
    logic                frame;
    logic                spause;
    logic [TICK_W-1:0]   ticks;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   rslot;
    logic [CALLS_W-1:0]  calls;
    logic [PERIOD_W-1:0] oldp;
    logic [ERR_W-1:0]    err;
    logic                last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CMD, ST_SCAN, ST_READ, ST_DIV, ST_EMIT, ST_DONE
  } exec_state_t;

endpackage

@@ sv/mtd_ram.sv @@
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module mtd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/mtd_front.sv @@
// Front end: input transaction accept and command queue.
`timescale 1ns / 1ps
module mtd_front #(
  parameter int DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mtd_pkg::cmd_t                 in_cmd,
  output logic                          q_valid,
  input  logic                          q_pop,
  output mtd_pkg::cmd_t                 q_cmd
);
  import mtd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          buf_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push;

  assign in_ready = (cnt_r != AW'(0) + (AW+1)'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = buf_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (q_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      buf_r[wp_r] <= in_cmd;
    end
  end
endmodule

@@ sv/mtd_divider.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mtd_divider #(
  parameter int W = 25,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [W-1:0]  quot,
  output logic [DW-1:0] rem
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [DW:0]   r_r, r_nxt;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   sh;

  assign quot = q_r;
  assign rem  = r_r[DW-1:0];
  assign done = busy_r && (cnt_r == '0);

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    sh       = {r_r[DW-1:0], q_r[W-1]};
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r != '0) begin
      if (sh >= {1'b0, d_r}) begin
        r_nxt = sh - {1'b0, d_r};
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = sh;
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end
endmodule

@@ sv/mtd_back.sv @@
// Back end: slot state, command execution and tick walk.
`timescale 1ns / 1ps
module mtd_back #(
  parameter int NUM_SLOTS   = 16,
  parameter int PERIOD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  mtd_pkg::cmd_t                 q_cmd,
  input  logic [mtd_pkg::CALLS_W-1:0]   cap,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mtd_pkg::res_t                 out_res
);
  import mtd_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int PB = PERIOD_BITS;
  localparam int DWD = ((PB > TICK_W) ? PB : TICK_W) + 1;
  localparam logic [PB-1:0] PMAX = {PB{1'b1}};

  exec_state_t   st_r, st_nxt;
  logic [NUM_SLOTS-1:0] act_r, act_nxt, pau_r, pau_nxt, sav_r, sav_nxt;
  logic [NUM_SLOTS-1:0] frm_r, frm_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic          ov_r, ov_nxt;
  res_t          res_r, res_nxt;

  logic          p_we, r_we;
  logic [SW-1:0] p_wa, r_wa, rd_a;
  logic [PB-1:0] p_wd, r_wd, p_rd, r_rd;

  logic          div_start, div_done;
  logic [DWD-1:0] div_q;
  logic [PB-1:0] div_r, per_c, clamped, per_eff;
  logic [DWD-1:0] sum;

  logic [NUM_SLOTS-1:0] free_v, run_v;
  logic [SW-1:0] free_i;
  logic          free_any;
  logic          slot_ok;
  logic [SW-1:0] cslot;
  logic [CALLS_W-1:0] calls_c;
  logic          out_free;

  mtd_ram #(.WIDTH(PB), .DEPTH(NUM_SLOTS)) u_per (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(rd_a), .rdata(p_rd));
  mtd_ram #(.WIDTH(PB), .DEPTH(NUM_SLOTS)) u_res (
    .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(rd_a), .rdata(r_rd));

  mtd_divider #(.W(DWD), .DW(PB)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum), .divisor(per_eff),
    .done(div_done), .quot(div_q), .rem(div_r));

  assign out_valid = ov_r;
  assign out_res   = res_r;
  assign out_free  = !ov_r || out_ready;

  assign per_c   = (q_cmd.period > 24'(PMAX)) ? PMAX : PB'(q_cmd.period);
  assign clamped = (per_c == '0) ? PB'(1) : per_c;
  assign per_eff = (p_rd == '0) ? PB'(1) : p_rd;
  assign sum     = DWD'(r_rd) + DWD'(q_cmd.ticks);
  assign free_v  = ~act_r;
  assign run_v   = act_r & ~pau_r;
  assign cslot   = SW'(q_cmd.slot);
  assign slot_ok = (32'(q_cmd.slot) < NUM_SLOTS) && act_r[cslot];

  always_comb begin
    free_i   = '0;
    free_any = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (free_v[i]) begin
        free_i   = SW'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    calls_c = (div_q > DWD'(16'hFFFF)) ? 16'hFFFF : CALLS_W'(div_q);
    if (cap != '0 && div_q > DWD'(cap)) begin
      calls_c = cap;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) st_nxt = (q_cmd.action == ACT_TICK) ? ST_SCAN : ST_CMD;
      ST_CMD:  if (out_free) st_nxt = ST_IDLE;
      ST_SCAN: st_nxt = run_v[idx_r] ? ST_READ : ((idx_r == SW'(NUM_SLOTS - 1)) ?
                        ST_DONE : ST_SCAN);
      ST_READ: st_nxt = frm_r[idx_r] ? ST_EMIT : ST_DIV;
      ST_DIV:  if (div_done) st_nxt = ST_EMIT;
      ST_EMIT: if (out_free) st_nxt = (idx_r == SW'(NUM_SLOTS - 1)) ? ST_DONE : ST_SCAN;
      ST_DONE: if (out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    act_nxt   = act_r;
    pau_nxt   = pau_r;
    sav_nxt   = sav_r;
    frm_nxt   = frm_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r && !out_ready;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    p_we      = 1'b0;
    p_wa      = cslot;
    p_wd      = clamped;
    r_we      = 1'b0;
    r_wa      = idx_r;
    r_wd      = '0;
    rd_a      = (st_r == ST_IDLE || st_r == ST_CMD) ? cslot : idx_r;
    div_start = 1'b0;
    case (st_r)
      ST_IDLE: begin
        idx_nxt = '0;
      end
      ST_CMD: begin
        if (out_free) begin
          q_pop   = 1'b1;
          ov_nxt  = 1'b1;
          res_nxt = '{KIND_ACK, '0, '0, '0, ERR_NONE, 1'b1};
          case (q_cmd.action)
            ACT_START: begin
              if (free_any) begin
                act_nxt[free_i] = 1'b1;
                pau_nxt[free_i] = q_cmd.spause;
                sav_nxt[free_i] = 1'b0;
                frm_nxt[free_i] = q_cmd.frame;
                p_we = 1'b1;
                p_wa = free_i;
                r_we = 1'b1;
                r_wa = free_i;
                res_nxt.rslot = SLOT_W'(free_i);
              end else begin
                res_nxt.kind = KIND_ERR;
                res_nxt.err  = ERR_NO_SLOT;
              end
            end
            ACT_STOP, ACT_PAUSE, ACT_RESUME, ACT_SET_PERIOD: begin
              if (!slot_ok) begin
                res_nxt.kind = KIND_ERR;
                res_nxt.err  = ERR_NOT_ACTIVE;
              end else if (q_cmd.action == ACT_STOP) begin
                act_nxt[cslot] = 1'b0;
              end else if (q_cmd.action == ACT_PAUSE) begin
                pau_nxt[cslot] = 1'b1;
              end else if (q_cmd.action == ACT_RESUME) begin
                pau_nxt[cslot] = 1'b0;
              end else begin
                p_we = 1'b1;
                res_nxt.oldp = PERIOD_W'(p_rd);
              end
            end
            ACT_SAVE_PAUSE: sav_nxt = (sav_r & ~act_r) | (pau_r & act_r);
            ACT_FREEZE_ALL: begin
              sav_nxt = (sav_r & ~act_r) | (pau_r & act_r);
              pau_nxt = pau_r | act_r;
            end
            ACT_RESUME_ALL: pau_nxt = (pau_r & ~act_r) | (sav_r & act_r);
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (!run_v[idx_r] && idx_r != SW'(NUM_SLOTS - 1)) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_READ: begin
        div_start = !frm_r[idx_r];
      end
      ST_DIV: ;
      ST_EMIT: begin
        if (out_free) begin
          ov_nxt  = 1'b1;
          r_we    = 1'b1;
          res_nxt = '{KIND_RUN, SLOT_W'(idx_r), calls_c, '0, ERR_NONE, 1'b0};
          if (frm_r[idx_r]) begin
            r_wd          = p_rd - 1'b1;
            res_nxt.calls = CALLS_W'(1);
          end else begin
            r_wd = div_r;
          end
          if (idx_r != SW'(NUM_SLOTS - 1)) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          q_pop   = 1'b1;
          ov_nxt  = 1'b1;
          res_nxt = '{KIND_DONE, '0, '0, '0, ERR_NONE, 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      act_r <= '0;
      pau_r <= '0;
      sav_r <= '0;
      frm_r <= '0;
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      act_r <= act_nxt;
      pau_r <= pau_nxt;
      sav_r <= sav_nxt;
      frm_r <= frm_nxt;
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
    res_r <= res_nxt;
  end
endmodule

@@ sv/multirate_task_dispatcher.sv @@
// Top level of the multirate task dispatcher.
`timescale 1ns / 1ps
// Usage:
//  Input channel in_valid/in_ready carries one command transaction (tick,
//  start, stop, pause, resume, save_pause, freeze_all, resume_all,
//  set_period). Output channel out_valid/out_ready returns result
//  transactions; out_last marks the final one of each command.
//  A two-entry command queue decouples accept from execution, so commands
//  are taken while the back end works or the receiver stalls.
//  Non-tick commands go from the queue through ST_CMD to a registered result.
//  Tick: the walk passes idle slots in ST_SCAN, emits once-per-frame slots
//  from ST_READ without the divider, and sends every other running slot
//  through the shared bit-serial divider in ST_DIV before ST_EMIT; a
//  tick-done result ends the walk.
//  cfg_we writes max_calls_per_tick at once; write only when idle.
//  Reset (rst_n low, synchronous) frees all slots, empties the queue and
//  clears the cap. Period and residual RAMs are not cleared; start writes
//  them before use. An output stall holds the result and halts the walk.
module multirate_task_dispatcher #(
  parameter int NUM_SLOTS   = 16,
  parameter int PERIOD_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_action,
  input  logic [3:0]  in_slot,
  input  logic [23:0] in_period_ticks,
  input  logic        in_once_per_frame,
  input  logic        in_start_paused,
  input  logic [15:0] in_tick_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_result_slot,
  output logic [15:0] out_call_count,
  output logic [23:0] out_old_period,
  output logic [1:0]  out_error_code,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import mtd_pkg::*;

  cmd_t               in_cmd, q_cmd;
  res_t               res;
  logic               q_valid, q_pop;
  logic [CALLS_W-1:0] cap_r;

  assign in_cmd = '{in_action, in_slot, in_period_ticks, in_once_per_frame,
                    in_start_paused, in_tick_count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  mtd_front #(.DEPTH(2)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

  mtd_back #(.NUM_SLOTS(NUM_SLOTS), .PERIOD_BITS(PERIOD_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .cap(cap_r), .out_valid(out_valid), .out_ready(out_ready), .out_res(res));

  assign out_kind        = res.kind;
  assign out_result_slot = res.rslot;
  assign out_call_count  = res.calls;
  assign out_old_period  = res.oldp;
  assign out_error_code  = res.err;
  assign out_last        = res.last;
endmodule

@@ sv/mtd_checker.sv @@
// Port-level checker for the multirate task dispatcher, bound to the top.
`timescale 1ns / 1ps
module mtd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [15:0] out_call_count,
  input logic [1:0]  out_error_code,
  input logic        out_last
);
  import mtd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last))
    else $error("output changed while stalled");
  a_run_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_RUN |-> !out_last)
    else $error("run result marked last");
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_ERR) == (out_error_code != ERR_NONE)))
    else $error("error code mismatch");
  a_calls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_RUN |-> out_call_count == '0)
    else $error("call count outside run result");
endmodule

bind multirate_task_dispatcher mtd_checker u_mtd_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_kind(out_kind), .out_call_count(out_call_count),
  .out_error_code(out_error_code), .out_last(out_last));

@@ dv/tb.sv @@
// Testbench for the multirate task dispatcher: random and directed command traffic.
`timescale 1ns / 1ps
module tb;
  import mtd_pkg::*;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 900000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_action = '0;
  logic [3:0]  in_slot = '0;
  logic [23:0] in_period_ticks = '0;
  logic        in_once_per_frame = 1'b0;
  logic        in_start_paused = 1'b0;
  logic [15:0] in_tick_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [3:0]  out_result_slot;
  logic [15:0] out_call_count;
  logic [23:0] out_old_period;
  logic [1:0]  out_error_code;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  multirate_task_dispatcher uut (.*);

  always #10 clk = ~clk;

  // scheduler shadow state
  logic [15:0] call_cap;
  logic [NSLOT-1:0] live_mask, hold_mask, saved_mask, frame_mask;
  logic [23:0] period_mem [NSLOT];
  logic [23:0] resid_mem [NSLOT];
  res_t due_q[$];

  int errors = 0;
  int cycles = 0;
  int runs_seen = 0;
  int sent = 0;
  bit quiet_out = 1'b0;
  bit quiet_in = 1'b0;
  int hold_off = 0;

  function automatic res_t mk(logic [1:0] k, logic [3:0] s, logic [15:0] c,
                              logic [23:0] o, logic [1:0] e, logic l);
    res_t r;
    r.kind = k; r.rslot = s; r.calls = c; r.oldp = o; r.err = e; r.last = l;
    return r;
  endfunction

  function automatic logic [23:0] fix_period(logic [23:0] p);
    return (p == 0) ? 24'd1 : p;
  endfunction

  task automatic dispatch_predict(cmd_t c);
    logic [39:0] sum;
    logic [39:0] p;
    logic [39:0] q;
    logic [NSLOT-1:0] b;
    bit found;
    b = '0;
    b[c.slot] = 1'b1;
    found = 1'b0;
    case (c.action)
      ACT_TICK: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!live_mask[i] || hold_mask[i]) continue;
          if (frame_mask[i]) begin
            q = 1;
            resid_mem[i] = period_mem[i] - 24'd1;
          end else begin
            p = (period_mem[i] == 0) ? 40'd1 : {16'd0, period_mem[i]};
            sum = {16'd0, resid_mem[i]} + {24'd0, c.ticks};
            resid_mem[i] = 24'(sum % p);
            q = sum / p;
            if (call_cap != 0 && q > {24'd0, call_cap}) q = {24'd0, call_cap};
            if (q > 40'hFFFF) q = 40'hFFFF;
          end
          due_q.push_back(mk(KIND_RUN, 4'(i), q[15:0], '0, ERR_NONE, 1'b0));
        end
        due_q.push_back(mk(KIND_DONE, '0, '0, '0, ERR_NONE, 1'b1));
      end
      ACT_START: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (live_mask[i]) continue;
          live_mask[i] = 1'b1;
          hold_mask[i] = c.spause;
          saved_mask[i] = 1'b0;
          frame_mask[i] = c.frame;
          period_mem[i] = fix_period(c.period);
          resid_mem[i] = '0;
          due_q.push_back(mk(KIND_ACK, 4'(i), '0, '0, ERR_NONE, 1'b1));
          found = 1'b1;
          break;
        end
        if (!found) due_q.push_back(mk(KIND_ERR, '0, '0, '0, ERR_NO_SLOT, 1'b1));
      end
      ACT_STOP, ACT_PAUSE, ACT_RESUME, ACT_SET_PERIOD: begin
        if (!live_mask[c.slot]) begin
          due_q.push_back(mk(KIND_ERR, '0, '0, '0, ERR_NOT_ACTIVE, 1'b1));
        end else if (c.action == ACT_SET_PERIOD) begin
          due_q.push_back(mk(KIND_ACK, '0, '0, period_mem[c.slot], ERR_NONE, 1'b1));
          period_mem[c.slot] = fix_period(c.period);
        end else begin
          if (c.action == ACT_STOP) live_mask &= ~b;
          else if (c.action == ACT_PAUSE) hold_mask |= b;
          else hold_mask &= ~b;
          due_q.push_back(mk(KIND_ACK, '0, '0, '0, ERR_NONE, 1'b1));
        end
      end
      default: begin
        if (c.action == ACT_SAVE_PAUSE || c.action == ACT_FREEZE_ALL)
          saved_mask = (saved_mask & ~live_mask) | (hold_mask & live_mask);
        if (c.action == ACT_FREEZE_ALL) hold_mask |= live_mask;
        if (c.action == ACT_RESUME_ALL)
          hold_mask = (hold_mask & ~live_mask) | (saved_mask & live_mask);
        due_q.push_back(mk(KIND_ACK, '0, '0, '0, ERR_NONE, 1'b1));
      end
    endcase
  endtask

  task automatic send_cmd(cmd_t c);
    @(negedge clk);
    while (!quiet_in && $urandom_range(99) < 34) @(negedge clk);
    in_valid <= 1'b1;
    in_action <= c.action;
    in_slot <= c.slot;
    in_period_ticks <= c.period;
    in_once_per_frame <= c.frame;
    in_start_paused <= c.spause;
    in_tick_count <= c.ticks;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    dispatch_predict(c);
    sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic cmd_t mkc(logic [3:0] a, logic [3:0] s, logic [23:0] p,
                               logic f, logic sp, logic [15:0] t);
    cmd_t c;
    c.action = a; c.slot = s; c.period = p; c.frame = f; c.spause = sp; c.ticks = t;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    c.action = 4'($urandom_range(8));
    r = $urandom_range(99);
    if (r < 4) c.action = 4'($urandom_range(15, 9));
    else if (r < 30) c.action = ACT_TICK;
    else if (r < 45) c.action = ACT_START;
    c.slot = 4'($urandom);
    r = $urandom_range(9);
    c.period = (r < 6) ? 24'($urandom_range(20)) : (r < 9 ? 24'($urandom_range(5000))
               : 24'($urandom));
    c.frame = ($urandom_range(5) == 0);
    c.spause = ($urandom_range(4) == 0);
    r = $urandom_range(9);
    c.ticks = (r < 7) ? 16'($urandom_range(100)) : 16'($urandom);
    return c;
  endfunction

  task automatic wait_drain();
    while (due_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_cap(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    call_cap = v;
  endtask

  task automatic test_directed();
    send_cmd(mkc(ACT_STOP, 4'd3, '0, 0, 0, '0));
    send_cmd(mkc(ACT_TICK, '0, '0, 0, 0, 16'hFFFF));
    send_cmd(mkc(ACT_START, '0, 24'd0, 0, 0, '0));
    send_cmd(mkc(ACT_START, '0, 24'hFFFFFF, 0, 0, '0));
    send_cmd(mkc(ACT_START, '0, 24'd7, 1, 0, '0));
    send_cmd(mkc(ACT_START, '0, 24'd3, 0, 1, '0));
    send_cmd(mkc(ACT_TICK, '0, '0, 0, 0, 16'hFFFF));
    send_cmd(mkc(ACT_PAUSE, 4'd0, '0, 0, 0, '0));
    send_cmd(mkc(ACT_SAVE_PAUSE, '0, '0, 0, 0, '0));
    send_cmd(mkc(ACT_FREEZE_ALL, '0, '0, 0, 0, '0));
    send_cmd(mkc(ACT_TICK, '0, '0, 0, 0, 16'd5));
    send_cmd(mkc(ACT_RESUME_ALL, '0, '0, 0, 0, '0));
    send_cmd(mkc(ACT_RESUME, 4'd0, '0, 0, 0, '0));
    send_cmd(mkc(ACT_SET_PERIOD, 4'd1, 24'd0, 0, 0, '0));
    send_cmd(mkc(ACT_SET_PERIOD, 4'd15, 24'd9, 0, 0, '0));
    send_cmd(mkc(4'd15, 4'd15, 24'hFFFFFF, 1, 1, 16'hFFFF));
    for (int i = 0; i < 13; i++) send_cmd(mkc(ACT_START, '0, 24'd1, 0, 0, '0));
    send_cmd(mkc(ACT_TICK, '0, '0, 0, 0, 16'hFFFF));
    send_cmd(mkc(ACT_STOP, 4'd15, '0, 0, 0, '0));
    wait_drain();
  endtask

  task automatic test_cap();
    write_cap(16'd1);
    send_cmd(mkc(ACT_TICK, '0, '0, 0, 0, 16'hFFFF));
    wait_drain();
    write_cap(16'hFFFF);
    send_cmd(mkc(ACT_TICK, '0, '0, 0, 0, 16'hFFFF));
    wait_drain();
    write_cap(16'd0);
    for (int i = 0; i < NSLOT; i++) send_cmd(mkc(ACT_STOP, 4'(i), '0, 0, 0, '0));
    wait_drain();
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 6; i++) send_cmd(mkc(ACT_START, '0, 24'($urandom_range(9)), 0, 0, '0));
    for (int i = 0; i < 4; i++) send_cmd(mkc(ACT_TICK, '0, '0, 0, 0, 16'd20));
    wait_drain();
  endtask

  task automatic test_random();
    logic [15:0] caps [4];
    caps[0] = 16'd0; caps[1] = 16'd3; caps[2] = 16'hFFFF; caps[3] = 16'd0;
    for (int ph = 0; ph < 4; ph++) begin
      write_cap(caps[ph]);
      quiet_in = (ph == 2);
      quiet_out = (ph == 2);
      for (int i = 0; i < 62; i++) send_cmd(rand_cmd());
      wait_drain();
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_out || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      got = mk(out_kind, out_result_slot, out_call_count, out_old_period,
               out_error_code, out_last);
      if (got.kind == KIND_RUN) runs_seen++;
      if (due_q.size() == 0) begin
        $display("%0t unexpected transaction: actual %p", $time, got);
        errors++;
      end else begin
        want = due_q.pop_front();
        if (got != want) begin
          $display("%0t mismatch: expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  initial begin
    call_cap = '0;
    live_mask = '0; hold_mask = '0; saved_mask = '0; frame_mask = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_cap();
    test_backpressure();
    test_random();
    wait_drain();
    $display("Sent %0d commands, checked %0d slot-run transactions,", sent, runs_seen);
    $display("covering caps, full table, pause save/restore and output stalls.");
    if (errors == 0 && due_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
